FILE: hw/rtl/plane_sphere_intersection_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the plane/sphere intersection block
// Define ASSERT_OFF to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef PLANE_SPHERE_INTERSECTION_MACROS_SVH
`define PLANE_SPHERE_INTERSECTION_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define PSI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("psi: assertion failed");
// condition must never be seen outside reset
`define PSI_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("psi: forbidden condition seen");
`else
`define PSI_ASSERT(lbl, prop)
`define PSI_NEVER(lbl, cond)
`endif
`endif

FILE: hw/rtl/psi_pkg.sv
// ----------------------------------------------------------------------------
// psi_pkg
// Shared widths, register indexes and word types of the plane/sphere block.
// ----------------------------------------------------------------------------
package psi_pkg;

  // fixed point formats
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NRM_W  = 16;             // normal component, Q2.14
  localparam int CRD_W  = 32;             // coordinate, Q16.16
  localparam int RAD_W  = 31;             // radius, unsigned Q15.16
  localparam int D_W    = 32;             // plane offset
  localparam int DEN_W  = 2 * NRM_W;      // a^2+b^2+c^2 fits here
  localparam int PROD_W = NRM_W + CRD_W;  // n_i * center_i

  // num = a*x + b*y + c*z + d*2^NFB, signed
  localparam int NUM_W = (((PROD_W + 2) > (D_W + NORMAL_FRAC_BITS)) ?
                          (PROD_W + 2) : (D_W + NORMAL_FRAC_BITS)) + 1;
  // |num| on a hit stays below 2^(RAD_W+NFB)
  localparam int MAG_W = RAD_W + NORMAL_FRAC_BITS;
  localparam int PP_W  = NRM_W + MAG_W;   // |n_i| * |num|
  // quotient bits kept; anything at or above 2^QB saturates the midpoint
  localparam int QB    = CRD_W + 1;
  localparam int SQ_W  = 2 * RAD_W;       // r^2 - nc^2
  localparam int SQ_STEPS = RAD_W;        // root bits
  localparam int SRM_W = RAD_W + 2;       // square root remainder
  localparam int DIF_W = CRD_W + 4;       // midpoint before saturation

  // decoupling queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // configuration registers
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = CFG_IDX_W'(3);
  localparam logic [NRM_W-1:0] NORMAL_ONE = NRM_W'(1) << NORMAL_FRAC_BITS;

  // input word
  typedef struct packed {
    logic signed [CRD_W-1:0] center_x;
    logic signed [CRD_W-1:0] center_y;
    logic signed [CRD_W-1:0] center_z;
    logic        [RAD_W-1:0] sphere_radius;
  } psi_in_t;

  // result word
  typedef struct packed {
    logic                    hit;
    logic                    degenerate;
    logic signed [CRD_W-1:0] mid_x;
    logic signed [CRD_W-1:0] mid_y;
    logic signed [CRD_W-1:0] mid_z;
    logic        [RAD_W-1:0] circle_radius;
  } psi_out_t;

  // front stage 1: products and squares
  typedef struct packed {
    logic [2:0][CRD_W-1:0]  ctr;
    logic [RAD_W-1:0]       radius;
    logic [2:0][NRM_W-1:0]  nrm;
    logic [2:0][PROD_W-1:0] prod;
    logic [2:0][DEN_W-1:0]  sq;
    logic [D_W-1:0]         d;
    logic                   degen;
  } psi_f1_t;

  // classified job handed from front to back
  typedef struct packed {
    logic                  hit;
    logic                  degen;
    logic                  neg_num;
    logic [MAG_W-1:0]      mnum;
    logic [2:0][CRD_W-1:0] ctr;
    logic [2:0][NRM_W-1:0] nrm;
    logic [DEN_W-1:0]      den;
    logic [RAD_W-1:0]      radius;
  } psi_job_t;

  // back stage 0: wide products
  typedef struct packed {
    logic                  hit;
    logic                  degen;
    logic [2:0]            neg;
    logic [2:0][CRD_W-1:0] ctr;
    logic [2:0][PP_W-1:0]  prod;
    logic [DEN_W-1:0]      den;
    logic [SQ_W-1:0]       rr;
    logic [SQ_W-1:0]       nn;
  } psi_b0_t;

  // one step of the divider / square root pipeline
  typedef struct packed {
    logic                  hit;
    logic                  degen;
    logic [2:0]            neg;
    logic [2:0]            ovf;
    logic [2:0][CRD_W-1:0] ctr;
    logic [DEN_W-1:0]      den;
    logic [2:0][DEN_W-1:0] rem;
    logic [2:0][QB-1:0]    lo;
    logic [SQ_W-1:0]       sv;
    logic [SRM_W-1:0]      srem;
    logic [RAD_W-1:0]      root;
  } psi_iter_t;

endpackage

FILE: hw/rtl/plane_sphere_intersection.sv
// ----------------------------------------------------------------------------
// plane_sphere_intersection
// Sphere against a configured plane: hit flag, circle midpoint and radius.
// ----------------------------------------------------------------------------
// Takes one sphere per clock while in_stall is low and returns one result
// word per sphere, in order. A sphere passes through two front stages that
// form num and classify, the job queue, a wide-product stage and a divider
// setup stage, then 33 stages of a bit-serial restoring divider (the square
// root runs alongside in the first 31) and the output register. The
// four-entry queue keeps the input flowing for a few words while the output
// is stalled. The user must write plane registers through cfg_* only while
// the block holds no work; the block does not enforce this. cfg_ready is always high.
// ----------------------------------------------------------------------------
module plane_sphere_intersection (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psi_pkg::D_W-1:0]       cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  psi_pkg::psi_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output psi_pkg::psi_out_t             out_data
);

  logic              q_push, q_full, q_pop, q_empty;
  psi_pkg::psi_job_t q_wdata, q_rdata;

  // classification
  psi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // job queue
  psi_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // division and square root
  psi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/psi_front.sv
// ----------------------------------------------------------------------------
// psi_front
// Plane registers, plane distance num and hit/degenerate classification.
// ----------------------------------------------------------------------------
module psi_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psi_pkg::D_W-1:0]        cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  psi_pkg::psi_in_t               in_data,
  input  logic                           q_full,
  output logic                           q_push,
  output psi_pkg::psi_job_t              q_wdata
);

  logic [psi_pkg::NRM_W-1:0] nx_r, ny_r, nz_r;
  logic [psi_pkg::D_W-1:0]   d_r;
  logic                      front_adv;
  logic                      f1_v_r, f2_v_r;
  psi_pkg::psi_f1_t          f1_r, f1_nxt;
  psi_pkg::psi_job_t         f2_r, f2_nxt;
  logic signed [psi_pkg::NUM_W-1:0] num;
  logic [psi_pkg::NUM_W-1:0]        mag;

  // plane registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= '0;
      ny_r <= psi_pkg::NORMAL_ONE;
      nz_r <= '0;
      d_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psi_pkg::REG_NORMAL_X:     nx_r <= cfg_data[psi_pkg::NRM_W-1:0];
        psi_pkg::REG_NORMAL_Y:     ny_r <= cfg_data[psi_pkg::NRM_W-1:0];
        psi_pkg::REG_NORMAL_Z:     nz_r <= cfg_data[psi_pkg::NRM_W-1:0];
        psi_pkg::REG_PLANE_OFFSET: d_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front moves unless its last stage waits on a full queue
  assign front_adv = !(f2_v_r && q_full);
  assign in_stall  = !front_adv;
  assign q_push    = f2_v_r && !q_full;
  assign q_wdata   = f2_r;

  // stage 1: normal times center, normal squared
  always_comb begin
    f1_nxt.ctr[0] = in_data.center_x;
    f1_nxt.ctr[1] = in_data.center_y;
    f1_nxt.ctr[2] = in_data.center_z;
    f1_nxt.radius = in_data.sphere_radius;
    f1_nxt.nrm[0] = nx_r;
    f1_nxt.nrm[1] = ny_r;
    f1_nxt.nrm[2] = nz_r;
    f1_nxt.d      = d_r;
    f1_nxt.degen  = (nx_r == '0) && (ny_r == '0) && (nz_r == '0);
    for (int i = 0; i < 3; i++) begin
      f1_nxt.prod[i] = psi_pkg::PROD_W'($signed(f1_nxt.nrm[i])) *
                       psi_pkg::PROD_W'($signed(f1_nxt.ctr[i]));
      f1_nxt.sq[i]   = psi_pkg::DEN_W'($signed(f1_nxt.nrm[i])) *
                       psi_pkg::DEN_W'($signed(f1_nxt.nrm[i]));
    end
  end

  // stage 2: sum to num, hit test, denominator
  always_comb begin
    num = psi_pkg::NUM_W'($signed(f1_r.prod[0])) +
          psi_pkg::NUM_W'($signed(f1_r.prod[1])) +
          psi_pkg::NUM_W'($signed(f1_r.prod[2])) +
          (psi_pkg::NUM_W'($signed(f1_r.d)) <<< psi_pkg::NORMAL_FRAC_BITS);
    mag = num[psi_pkg::NUM_W-1] ? psi_pkg::NUM_W'(-num) : psi_pkg::NUM_W'(num);
    f2_nxt.degen   = f1_r.degen;
    f2_nxt.hit     = !f1_r.degen &&
                     (mag <= (psi_pkg::NUM_W'(f1_r.radius) << psi_pkg::NORMAL_FRAC_BITS));
    f2_nxt.neg_num = num[psi_pkg::NUM_W-1];
    f2_nxt.mnum    = mag[psi_pkg::MAG_W-1:0];
    f2_nxt.ctr     = f1_r.ctr;
    f2_nxt.nrm     = f1_r.nrm;
    f2_nxt.den     = f1_r.sq[0] + f1_r.sq[1] + f1_r.sq[2];
    f2_nxt.radius  = f1_r.radius;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (front_adv) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (front_adv) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
    end
  end

endmodule

FILE: hw/rtl/psi_queue.sv
// ----------------------------------------------------------------------------
// psi_queue
// Short FIFO of classified jobs between front and back.
// ----------------------------------------------------------------------------
`include "plane_sphere_intersection_macros.svh"

module psi_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  psi_pkg::psi_job_t wdata,
  output logic              full,
  input  logic              pop,
  output psi_pkg::psi_job_t rdata,
  output logic              empty
);

  psi_pkg::psi_job_t              mem_r [psi_pkg::QDEPTH];
  logic [psi_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [psi_pkg::QPTR_W:0]       cnt_r;

  assign full  = (cnt_r == (psi_pkg::QPTR_W+1)'(psi_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  `PSI_NEVER(a_q_overflow, push && full && !pop)
  `PSI_NEVER(a_q_underflow, pop && empty)

endmodule

FILE: hw/rtl/psi_back.sv
// ----------------------------------------------------------------------------
// psi_back
// Midpoint division and circle radius square root, one bit per stage.
// ----------------------------------------------------------------------------
`include "plane_sphere_intersection_macros.svh"

module psi_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  psi_pkg::psi_job_t q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output psi_pkg::psi_out_t out_data
);

  logic                        adv;
  logic                        b0_v_r;
  psi_pkg::psi_b0_t            b0_r, b0_nxt;
  logic [psi_pkg::QB:0]        stg_v_r;
  psi_pkg::psi_iter_t          stg_r [psi_pkg::QB+1];
  psi_pkg::psi_iter_t          s0_nxt;
  psi_pkg::psi_iter_t          step_nxt [psi_pkg::QB];
  logic                        out_valid_r;
  psi_pkg::psi_out_t           out_r, out_nxt;
  logic [psi_pkg::NRM_W-1:0]   mag_n [3];
  logic [psi_pkg::RAD_W-1:0]   nc;
  logic [psi_pkg::PP_W-1:0]    hi [3];

  // one restoring divide step on each axis, one root bit when enabled
  function automatic psi_pkg::psi_iter_t iter_step(input psi_pkg::psi_iter_t s,
                                                   input logic do_sq);
    psi_pkg::psi_iter_t               n;
    logic [psi_pkg::DEN_W:0]          t;
    logic                             ge;
    logic [psi_pkg::SRM_W+1:0]        st, trial;
    logic                             sge;
    n = s;
    for (int i = 0; i < 3; i++) begin
      t  = {s.rem[i], s.lo[i][psi_pkg::QB-1]};
      ge = t >= {1'b0, s.den};
      n.rem[i] = ge ? psi_pkg::DEN_W'(t - {1'b0, s.den}) : t[psi_pkg::DEN_W-1:0];
      n.lo[i]  = {s.lo[i][psi_pkg::QB-2:0], ge};
    end
    if (do_sq) begin
      st     = {s.srem, s.sv[psi_pkg::SQ_W-1 -: 2]};
      trial  = (psi_pkg::SRM_W+2)'({s.root, 2'b01});
      sge    = st >= trial;
      n.srem = sge ? psi_pkg::SRM_W'(st - trial) : psi_pkg::SRM_W'(st);
      n.root = {s.root[psi_pkg::RAD_W-2:0], sge};
      n.sv   = {s.sv[psi_pkg::SQ_W-3:0], 2'b00};
    end
    return n;
  endfunction

  // center minus signed offset, clamped to the coordinate range
  function automatic logic [psi_pkg::CRD_W-1:0] sat_mid(
      input logic [psi_pkg::CRD_W-1:0] c,
      input logic [psi_pkg::QB-1:0]    q,
      input logic                      neg);
    logic signed [psi_pkg::DIF_W-1:0]         off, diff;
    logic [psi_pkg::DIF_W-psi_pkg::CRD_W:0]   upper;
    logic [psi_pkg::CRD_W-1:0]                res;
    off   = neg ? -$signed(psi_pkg::DIF_W'(q)) : $signed(psi_pkg::DIF_W'(q));
    diff  = $signed(psi_pkg::DIF_W'($signed(c))) - off;
    upper = diff[psi_pkg::DIF_W-1:psi_pkg::CRD_W-1];
    if (upper == '0 || upper == '1) begin
      res = diff[psi_pkg::CRD_W-1:0];
    end else if (diff[psi_pkg::DIF_W-1]) begin
      res = {1'b1, {(psi_pkg::CRD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(psi_pkg::CRD_W-1){1'b1}}};
    end
    return res;
  endfunction

  // whole back pipeline holds while the result word is not taken
  assign adv       = !(out_valid_r && out_stall);
  assign q_pop     = adv && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stage 0: |n_i| * |num|, r^2 and nc^2
  always_comb begin
    nc = q_rdata.mnum[psi_pkg::MAG_W-1:psi_pkg::NORMAL_FRAC_BITS];
    b0_nxt.hit   = q_rdata.hit;
    b0_nxt.degen = q_rdata.degen;
    b0_nxt.ctr   = q_rdata.ctr;
    b0_nxt.den   = q_rdata.den;
    for (int i = 0; i < 3; i++) begin
      mag_n[i] = q_rdata.nrm[i][psi_pkg::NRM_W-1] ? -q_rdata.nrm[i] : q_rdata.nrm[i];
      b0_nxt.neg[i]  = q_rdata.nrm[i][psi_pkg::NRM_W-1] ^ q_rdata.neg_num;
      b0_nxt.prod[i] = psi_pkg::PP_W'(mag_n[i]) * psi_pkg::PP_W'(q_rdata.mnum);
    end
    b0_nxt.rr = psi_pkg::SQ_W'(q_rdata.radius) * psi_pkg::SQ_W'(q_rdata.radius);
    b0_nxt.nn = psi_pkg::SQ_W'(nc) * psi_pkg::SQ_W'(nc);
  end

  // stage 1: divider setup, overflow check, root operand
  always_comb begin
    s0_nxt.hit   = b0_r.hit;
    s0_nxt.degen = b0_r.degen;
    s0_nxt.neg   = b0_r.neg;
    s0_nxt.ctr   = b0_r.ctr;
    s0_nxt.den   = b0_r.den;
    for (int i = 0; i < 3; i++) begin
      hi[i]         = b0_r.prod[i] >> psi_pkg::QB;
      s0_nxt.ovf[i] = hi[i] >= psi_pkg::PP_W'(b0_r.den);
      s0_nxt.rem[i] = hi[i][psi_pkg::DEN_W-1:0];
      s0_nxt.lo[i]  = b0_r.prod[i][psi_pkg::QB-1:0];
    end
    s0_nxt.sv   = b0_r.rr - b0_r.nn;
    s0_nxt.srem = '0;
    s0_nxt.root = '0;
  end

  // iteration stages
  for (genvar k = 0; k < psi_pkg::QB; k++) begin : g_step
    always_comb step_nxt[k] = iter_step(stg_r[k], (k < psi_pkg::SQ_STEPS));
  end

  // result word
  always_comb begin
    out_nxt = '0;
    out_nxt.degenerate = stg_r[psi_pkg::QB].degen;
    if (stg_r[psi_pkg::QB].hit) begin
      out_nxt.hit = 1'b1;
      out_nxt.mid_x = sat_mid(stg_r[psi_pkg::QB].ctr[0],
                              stg_r[psi_pkg::QB].ovf[0] ? '1 : stg_r[psi_pkg::QB].lo[0],
                              stg_r[psi_pkg::QB].neg[0]);
      out_nxt.mid_y = sat_mid(stg_r[psi_pkg::QB].ctr[1],
                              stg_r[psi_pkg::QB].ovf[1] ? '1 : stg_r[psi_pkg::QB].lo[1],
                              stg_r[psi_pkg::QB].neg[1]);
      out_nxt.mid_z = sat_mid(stg_r[psi_pkg::QB].ctr[2],
                              stg_r[psi_pkg::QB].ovf[2] ? '1 : stg_r[psi_pkg::QB].lo[2],
                              stg_r[psi_pkg::QB].neg[2]);
      out_nxt.circle_radius = stg_r[psi_pkg::QB].root;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r      <= 1'b0;
      stg_v_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b0_v_r      <= q_pop;
      stg_v_r     <= {stg_v_r[psi_pkg::QB-1:0], b0_v_r};
      out_valid_r <= stg_v_r[psi_pkg::QB];
    end
  end

  // payload chain
  always_ff @(posedge clk) begin
    if (adv) begin
      b0_r     <= b0_nxt;
      stg_r[0] <= s0_nxt;
      for (int k = 0; k < psi_pkg::QB; k++) begin
        stg_r[k+1] <= step_nxt[k];
      end
      out_r    <= out_nxt;
    end
  end

  `PSI_NEVER(a_pop_while_held, q_pop && out_valid_r && out_stall)
  `PSI_NEVER(a_hit_and_degen, out_valid_r && out_r.hit && out_r.degenerate)
  `PSI_ASSERT(a_miss_zero_radius, (out_valid_r && !out_r.hit) |-> (out_r.circle_radius == '0))

endmodule

FILE: dv/tb_plane_sphere_intersection.sv
// ----------------------------------------------------------------------------
// tb_plane_sphere_intersection
// Streams spheres through the block under several plane settings and idling
// mixes, predicts every result word in the bench and checks each one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_plane_sphere_intersection;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  // index outside the register map; writes to it are dropped
  localparam logic [psi_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = psi_pkg::CFG_IDX_W'(5);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [psi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [psi_pkg::D_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  psi_pkg::psi_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  psi_pkg::psi_out_t out_data;

  // plane copy kept by the bench
  logic signed [psi_pkg::NRM_W-1:0] plane_nx = 16'sd0;
  logic signed [psi_pkg::NRM_W-1:0] plane_ny = 16'sd16384;
  logic signed [psi_pkg::NRM_W-1:0] plane_nz = 16'sd0;
  logic signed [psi_pkg::D_W-1:0] plane_d = '0;

  psi_pkg::psi_in_t sphere_q[$];
  psi_pkg::psi_out_t result_q[$];
  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int cycles = 0;

  plane_sphere_intersection dut (.*);

  always #5 clk = ~clk;

  // floor of the square root of a 62-bit value
  function automatic logic [psi_pkg::RAD_W-1:0] root_floor(longint unsigned v);
    longint unsigned res, t;
    res = 0;
    for (int i = 31; i >= 0; i--) begin
      t = res | (64'd1 << i);
      if (t * t <= v) res = t;
    end
    return psi_pkg::RAD_W'(res);
  endfunction

  // center minus n*num/den, truncated on magnitudes, then saturated
  function automatic logic [psi_pkg::CRD_W-1:0] mid_coord(longint ctr, longint n,
                                                          longint num,
                                                          longint unsigned den);
    logic [127:0] prod, quo;
    longint unsigned q;
    longint res;
    prod = 128'(n < 0 ? -n : n) * 128'(num < 0 ? -num : num);
    quo = prod / 128'(den);
    q = (quo >= (128'd1 << 41)) ? (64'd1 << 41) : quo[63:0];
    res = ((n < 0) != (num < 0)) ? ctr + longint'(q) : ctr - longint'(q);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[psi_pkg::CRD_W-1:0];
  endfunction

  function automatic psi_pkg::psi_out_t sphere_cut(psi_pkg::psi_in_t s);
    longint a, b, c, num;
    longint unsigned r, den, mnum, nc;
    psi_pkg::psi_out_t o;
    o = '0;
    a = plane_nx;
    b = plane_ny;
    c = plane_nz;
    r = s.sphere_radius;
    den = a * a + b * b + c * c;
    if (den == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    num = a * s.center_x + b * s.center_y + c * s.center_z +
          (longint'(plane_d) <<< psi_pkg::NORMAL_FRAC_BITS);
    mnum = num < 0 ? -num : num;
    if (mnum > (r << psi_pkg::NORMAL_FRAC_BITS)) return o;
    o.hit = 1'b1;
    o.mid_x = mid_coord(s.center_x, a, num, den);
    o.mid_y = mid_coord(s.center_y, b, num, den);
    o.mid_z = mid_coord(s.center_z, c, num, den);
    nc = mnum >> psi_pkg::NORMAL_FRAC_BITS;
    if (nc > r) nc = r;
    o.circle_radius = root_floor(r * r - nc * nc);
    return o;
  endfunction

  function automatic psi_pkg::psi_in_t sphere(int x, int y, int z, int unsigned r);
    psi_pkg::psi_in_t s;
    s.center_x = x;
    s.center_y = y;
    s.center_z = z;
    s.sphere_radius = psi_pkg::RAD_W'(r);
    return s;
  endfunction

  // mostly spheres near the origin with wide radii so hits are common
  function automatic psi_pkg::psi_in_t rand_sphere();
    psi_pkg::psi_in_t s;
    int sh;
    s = {$urandom, $urandom, $urandom, psi_pkg::RAD_W'($urandom)};
    case ($urandom_range(3))
      0: ;
      3: s.sphere_radius = '1;
      default: begin
        sh = $urandom_range(8, 22);
        s.center_x = $signed($urandom) >>> sh;
        s.center_y = $signed($urandom) >>> sh;
        s.center_z = $signed($urandom) >>> sh;
        s.sphere_radius = psi_pkg::RAD_W'($urandom >> $urandom_range(1, 14));
      end
    endcase
    return s;
  endfunction

  // sender: one word per handshake, prediction taken at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        result_q.push_back(sphere_cut(in_data));
        void'(sphere_q.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (sphere_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_data <= sphere_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall, compare each accepted word with oldest prediction
  always @(posedge clk) begin
    psi_pkg::psi_out_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        errors++;
      end else begin
        exp_w = result_q.pop_front();
        if (out_data.hit !== exp_w.hit) begin
          $display("%0t: hit exp %b got %b", $time, exp_w.hit, out_data.hit);
          errors++;
        end
        if (out_data.degenerate !== exp_w.degenerate) begin
          $display("%0t: degenerate exp %b got %b", $time, exp_w.degenerate,
                   out_data.degenerate);
          errors++;
        end
        if (out_data.mid_x !== exp_w.mid_x) begin
          $display("%0t: mid_x exp %h got %h", $time, exp_w.mid_x, out_data.mid_x);
          errors++;
        end
        if (out_data.mid_y !== exp_w.mid_y) begin
          $display("%0t: mid_y exp %h got %h", $time, exp_w.mid_y, out_data.mid_y);
          errors++;
        end
        if (out_data.mid_z !== exp_w.mid_z) begin
          $display("%0t: mid_z exp %h got %h", $time, exp_w.mid_z, out_data.mid_z);
          errors++;
        end
        if (out_data.circle_radius !== exp_w.circle_radius) begin
          $display("%0t: circle_radius exp %h got %h", $time, exp_w.circle_radius,
                   out_data.circle_radius);
          errors++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL plane_sphere_intersection");
      $finish;
    end
  end

  task automatic reg_write(logic [psi_pkg::CFG_IDX_W-1:0] idx,
                           logic [psi_pkg::D_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      psi_pkg::REG_NORMAL_X: plane_nx = val[psi_pkg::NRM_W-1:0];
      psi_pkg::REG_NORMAL_Y: plane_ny = val[psi_pkg::NRM_W-1:0];
      psi_pkg::REG_NORMAL_Z: plane_nz = val[psi_pkg::NRM_W-1:0];
      psi_pkg::REG_PLANE_OFFSET: plane_d = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_plane(int nx, int ny, int nz, int d);
    reg_write(psi_pkg::REG_NORMAL_X, psi_pkg::D_W'(nx));
    reg_write(psi_pkg::REG_NORMAL_Y, psi_pkg::D_W'(ny));
    reg_write(psi_pkg::REG_NORMAL_Z, psi_pkg::D_W'(nz));
    reg_write(psi_pkg::REG_PLANE_OFFSET, psi_pkg::D_W'(d));
  endtask

  // waits until every sphere is sent and every predicted word is back, then block settles
  task automatic drain();
    while (sphere_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int n, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++) sphere_q.push_back(rand_sphere());
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset plane y = 0: touching, crossing, missing, field extremes
    sphere_q.push_back(sphere(0, 0, 0, 0));
    sphere_q.push_back(sphere(0, 65536, 0, 65536));
    sphere_q.push_back(sphere(0, 65537, 0, 65536));
    sphere_q.push_back(sphere(0, -65536, 0, 131072));
    sphere_q.push_back(sphere(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    sphere_q.push_back(sphere(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff));
    sphere_q.push_back(sphere(32'h80000000, 0, 32'h7fffffff, 1234));
    sphere_q.push_back(sphere(-5, 3, 7, 32'h40000000));
    run_random(130, 0, 0);

    // x plane at the low offset limit: midpoint saturates high; dropped write
    reg_write(REG_UNMAPPED, 32'h1234_5678);
    set_plane(16384, 0, 0, 32'h80000000);
    sphere_q.push_back(sphere(32'h7fffffff, 0, 0, 1));
    sphere_q.push_back(sphere(32'h7fffffff, -1, 1, 32'h7fffffff));
    sphere_q.push_back(sphere(32'h80000000, 0, 0, 32'h7fffffff));
    run_random(130, 68, 0);

    // tiny normal: quotient clamps, midpoint saturates both ways
    set_plane(1, 0, -1, $urandom);
    sphere_q.push_back(sphere(32'h7fffffff, 0, 32'h80000000, 32'h7fffffff));
    sphere_q.push_back(sphere(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff));
    run_random(130, 0, 68);

    // normal extremes, high offset
    set_plane(32767, -32768, -32768, 32'h7fffffff);
    run_random(130, 21, 21);

    // zero normal: every sphere is degenerate
    set_plane(0, 0, 0, $urandom);
    sphere_q.push_back(sphere(0, 0, 0, 0));
    sphere_q.push_back(sphere(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff));
    run_random(10, 0, 0);

    // random planes to finish
    for (int p = 0; p < 3; p++) begin
      set_plane($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                $signed($urandom) >>> $urandom_range(0, 20));
      run_random(25, p == 1 ? 68 : 0, p == 2 ? 68 : 0);
    end

    if (errors == 0) begin
      $display("PASS plane_sphere_intersection");
    end else begin
      $display("FAIL plane_sphere_intersection");
    end
    $finish;
  end

endmodule
